>>> hdl/pscrc_pkg.sv
package pscrc_pkg;

    // Fixed field widths of the ports
    localparam int OP_W       = 2;
    localparam int ID_IN_W    = 6;
    localparam int SLOT_OUT_W = 4;
    localparam int CFG_W      = 4;
    localparam int CNT_W      = 8;

    // Default sizes and reset values
    localparam int NUM_PALETTES_DEF = 64;
    localparam int NUM_SLOTS_DEF    = 16;
    localparam int FIRST_SLOT_RST   = 5;
    localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

    typedef enum logic [OP_W-1:0] {
        OP_USE   = 2'd0,
        OP_UNUSE = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_WT,
        ST_SRCH,
        ST_SRCH_WT,
        ST_OWN_RD,
        ST_OWN_WT,
        ST_CNT_RD,
        ST_CNT_WT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic map_latch;
        logic srch_issue;
        logic srch_step;
        logic srch_hit;
        logic srch_miss;
        logic own_apply;
        logic cnt_rd;
        logic cnt_apply;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_op  op;
        logic map_zero;
        logic tries_zero;
        logic cnt_zero;
    } t_stat;

endpackage

>>> hdl/pscrc_ram.sv
module pscrc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/pscrc_ctrl.sv
module pscrc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  pscrc_pkg::t_stat i_stat,
    output pscrc_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    pscrc_pkg::t_state r_state;
    pscrc_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pscrc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pscrc_pkg::ST_IDLE: begin
                if (i_start) n_state = pscrc_pkg::ST_MAP_WT;
            end
            pscrc_pkg::ST_MAP_WT: begin
                priority if (i_stat.op == pscrc_pkg::OP_USE && i_stat.map_zero)
                    n_state = pscrc_pkg::ST_SRCH;
                else if (i_stat.op == pscrc_pkg::OP_FREE)
                    n_state = pscrc_pkg::ST_OWN_RD;
                else
                    n_state = pscrc_pkg::ST_CNT_RD;
            end
            pscrc_pkg::ST_SRCH: begin
                n_state = i_stat.tries_zero ? pscrc_pkg::ST_CNT_RD : pscrc_pkg::ST_SRCH_WT;
            end
            pscrc_pkg::ST_SRCH_WT: begin
                n_state = i_stat.cnt_zero ? pscrc_pkg::ST_OWN_RD : pscrc_pkg::ST_SRCH;
            end
            pscrc_pkg::ST_OWN_RD:  n_state = pscrc_pkg::ST_OWN_WT;
            pscrc_pkg::ST_OWN_WT:  n_state = pscrc_pkg::ST_CNT_RD;
            pscrc_pkg::ST_CNT_RD:  n_state = pscrc_pkg::ST_CNT_WT;
            pscrc_pkg::ST_CNT_WT:  n_state = pscrc_pkg::ST_IDLE;
            default:               n_state = pscrc_pkg::ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            pscrc_pkg::ST_IDLE:    o_cmd.capture   = i_start;
            pscrc_pkg::ST_MAP_WT:  o_cmd.map_latch = 1'b1;
            pscrc_pkg::ST_SRCH: begin
                o_cmd.srch_miss  = i_stat.tries_zero;
                o_cmd.srch_issue = !i_stat.tries_zero;
            end
            pscrc_pkg::ST_SRCH_WT: begin
                o_cmd.srch_hit  = i_stat.cnt_zero;
                o_cmd.srch_step = !i_stat.cnt_zero;
            end
            pscrc_pkg::ST_OWN_RD:  o_cmd = '0;
            pscrc_pkg::ST_OWN_WT:  o_cmd.own_apply = 1'b1;
            pscrc_pkg::ST_CNT_RD:  o_cmd.cnt_rd    = 1'b1;
            pscrc_pkg::ST_CNT_WT:  o_cmd.cnt_apply = 1'b1;
            default:               o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != pscrc_pkg::ST_IDLE);

endmodule

>>> hdl/pscrc_dp.sv
module pscrc_dp #(
    parameter int NUM_PALETTES = pscrc_pkg::NUM_PALETTES_DEF,
    parameter int NUM_SLOTS    = pscrc_pkg::NUM_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [pscrc_pkg::OP_W-1:0]        i_operation,
    input  logic [pscrc_pkg::ID_IN_W-1:0]     i_palette_id,
    input  logic                              i_cfg_we,
    input  logic [pscrc_pkg::CFG_W-1:0]       i_cfg_data,
    input  pscrc_pkg::t_cmd                   i_cmd,
    output pscrc_pkg::t_stat                  o_stat,
    output logic                              o_done,
    output logic [pscrc_pkg::SLOT_OUT_W-1:0]  o_slot,
    output logic                              o_load_request
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int PW = $clog2(NUM_SLOTS + 1);
    localparam int IW = $clog2(NUM_PALETTES);
    localparam int CW = (PW > pscrc_pkg::CFG_W) ? PW : pscrc_pkg::CFG_W;
    localparam int CNT_W = pscrc_pkg::CNT_W;
    localparam int ID_ENTRIES = 2 ** pscrc_pkg::ID_IN_W;
    // Out-of-range reset pointer behaves like any other out-of-range pointer
    localparam logic [PW-1:0] PTR_RST = (pscrc_pkg::FIRST_SLOT_RST < NUM_SLOTS) ?
        PW'(pscrc_pkg::FIRST_SLOT_RST) : PW'(NUM_SLOTS);

    logic [pscrc_pkg::CFG_W-1:0] r_first_slot;
    pscrc_pkg::t_op              r_op;
    logic [IW-1:0]               r_id;
    logic [SW-1:0]               r_s;
    logic [PW-1:0]               r_ptr;
    logic [PW-1:0]               r_p;
    logic [PW-1:0]               r_tries;
    logic                        r_load;
    logic [NUM_PALETTES-1:0]     r_map_vld;
    logic [NUM_PALETTES-1:0]     n_map_vld;
    logic [NUM_SLOTS-1:0]        r_own_vld;
    logic [NUM_SLOTS-1:0]        n_own_vld;
    logic [NUM_SLOTS-1:0]        r_cnt_vld;
    logic [NUM_SLOTS-1:0]        n_cnt_vld;
    logic                        r_map_rv;
    logic                        r_cnt_rv;
    logic                        r_cnt_rz;
    logic                        r_done;
    logic [pscrc_pkg::SLOT_OUT_W-1:0] r_out_slot;
    logic                        r_out_load;

    logic [IW-1:0]    w_id_lut [ID_ENTRIES];
    logic [IW-1:0]    w_in_id;
    logic [CW-1:0]    w_lo;
    logic [CW-1:0]    w_ns;
    logic [CW-1:0]    w_p_ext;
    logic [PW-1:0]    w_tries0;
    logic [PW-1:0]    w_pe;
    logic [SW-1:0]    w_map_rdata;
    logic [SW-1:0]    w_map_s;
    logic             w_map_we;
    logic [SW-1:0]    w_cnt_raddr;
    logic [CNT_W-1:0] w_cnt_rdata;
    logic [CNT_W-1:0] w_cnt;
    logic [CNT_W-1:0] w_cnt_new;
    logic             w_cnt_we;
    logic [IW-1:0]    w_own_rdata;
    logic             w_own_we;

    // Palette id folded into the table range, built at elaboration
    for (genvar g = 0; g < ID_ENTRIES; g++) begin : g_id_lut
        assign w_id_lut[g] = IW'(g % NUM_PALETTES);
    end
    assign w_in_id = w_id_lut[i_palette_id];

    // Search bounds
    assign w_lo     = (r_first_slot == '0) ? CW'(1) : CW'(r_first_slot);
    assign w_ns     = CW'(NUM_SLOTS);
    assign w_tries0 = (w_lo >= w_ns) ? '0 : PW'(w_ns - w_lo);
    assign w_p_ext  = CW'(r_p);
    assign w_pe     = (w_p_ext >= w_ns || w_p_ext < w_lo) ? PW'(w_lo) : r_p;

    // palette -> slot map
    assign w_map_we = i_cmd.own_apply && (r_op == pscrc_pkg::OP_USE);

    pscrc_ram #(.W(SW), .D(NUM_PALETTES)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (r_id),
        .i_wdata (r_s),
        .i_raddr (w_in_id),
        .o_rdata (w_map_rdata)
    );

    assign w_map_s = r_map_rv ? w_map_rdata : '0;

    // slot -> owner map
    assign w_own_we = w_map_we;

    pscrc_ram #(.W(IW), .D(NUM_SLOTS)) u_own_ram (
        .i_clk   (i_clk),
        .i_we    (w_own_we),
        .i_waddr (r_s),
        .i_wdata (r_id),
        .i_raddr (r_s),
        .o_rdata (w_own_rdata)
    );

    // use counts; unwritten entries read as reset value
    assign w_cnt_raddr = i_cmd.cnt_rd ? r_s : w_pe[SW-1:0];
    assign w_cnt_we    = i_cmd.cnt_apply && (r_op != pscrc_pkg::OP_NOP);

    pscrc_ram #(.W(CNT_W), .D(NUM_SLOTS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (r_s),
        .i_wdata (w_cnt_new),
        .i_raddr (w_cnt_raddr),
        .o_rdata (w_cnt_rdata)
    );

    assign w_cnt = r_cnt_rv ? w_cnt_rdata : (r_cnt_rz ? CNT_W'(1) : '0);

    // Count update per operation, saturating both ways
    always_comb begin
        w_cnt_new = w_cnt;
        unique case (r_op)
            pscrc_pkg::OP_USE:   w_cnt_new = (w_cnt < pscrc_pkg::COUNT_MAX) ? w_cnt + 1'b1 : w_cnt;
            pscrc_pkg::OP_UNUSE: w_cnt_new = (w_cnt != '0) ? w_cnt - 1'b1 : w_cnt;
            pscrc_pkg::OP_FREE:  w_cnt_new = '0;
            pscrc_pkg::OP_NOP:   w_cnt_new = w_cnt;
        endcase
    end

    // Valid bit updates: steal, bind, unbind
    always_comb begin
        n_map_vld = r_map_vld;
        n_own_vld = r_own_vld;
        n_cnt_vld = r_cnt_vld;
        if (i_cmd.own_apply) begin
            if (r_op == pscrc_pkg::OP_USE) begin
                if (r_own_vld[r_s]) n_map_vld[w_own_rdata] = 1'b0;
                n_map_vld[r_id] = 1'b1;
                n_own_vld[r_s]  = 1'b1;
            end else begin
                n_map_vld[r_id] = 1'b0;
                if (r_s != '0 && r_own_vld[r_s] && w_own_rdata == r_id)
                    n_own_vld[r_s] = 1'b0;
            end
        end
        if (w_cnt_we) n_cnt_vld[r_s] = 1'b1;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_slot <= pscrc_pkg::CFG_W'(pscrc_pkg::FIRST_SLOT_RST);
            r_ptr        <= PTR_RST;
            r_map_vld    <= '0;
            r_own_vld    <= '0;
            r_cnt_vld    <= '0;
            r_done       <= 1'b0;
        end else begin
            if (i_cfg_we) r_first_slot <= i_cfg_data;
            if (i_cmd.srch_hit || i_cmd.srch_miss) r_ptr <= r_p;
            r_map_vld <= n_map_vld;
            r_own_vld <= n_own_vld;
            r_cnt_vld <= n_cnt_vld;
            r_done    <= i_cmd.cnt_apply;
        end
    end

    // Working registers of the current item
    always_ff @(posedge i_clk) begin
        r_map_rv <= r_map_vld[w_in_id];
        r_cnt_rv <= r_cnt_vld[w_cnt_raddr];
        r_cnt_rz <= (w_cnt_raddr == '0);
        if (i_cmd.capture) begin
            r_op   <= pscrc_pkg::t_op'(i_operation);
            r_id   <= w_in_id;
            r_load <= 1'b0;
        end
        if (i_cmd.map_latch) begin
            r_s     <= w_map_s;
            r_p     <= r_ptr;
            r_tries <= w_tries0;
        end
        if (i_cmd.srch_issue) r_p <= w_pe;
        if (i_cmd.srch_step) begin
            r_p     <= r_p + 1'b1;
            r_tries <= r_tries - 1'b1;
        end
        if (i_cmd.srch_hit) begin
            r_s    <= r_p[SW-1:0];
            r_load <= 1'b1;
        end
        if (i_cmd.srch_miss) r_s <= '0;
        if (i_cmd.cnt_apply) begin
            r_out_slot <= pscrc_pkg::SLOT_OUT_W'(r_s);
            r_out_load <= r_load;
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.map_zero   = (w_map_s == '0);
    assign o_stat.tries_zero = (r_tries == '0);
    assign o_stat.cnt_zero   = (w_cnt == '0);

    assign o_done         = r_done;
    assign o_slot         = r_out_slot;
    // Load flag only shown together with its result strobe
    assign o_load_request = r_done && r_out_load;

endmodule

>>> hdl/palette_slot_refcount_cache_top.sv
// Channel   Direction  Signals                                  Transfer
// command   in         start, busy, i_operation, i_palette_id   start && !busy
// result    out        o_done, o_slot, o_load_request           o_done, one cycle
// config    in         i_cfg_valid, o_cfg_ready, i_cfg_data     valid && ready
//
// Unuse, nop and a use of a bound id go straight to the count update; free
// also updates the owner map; a use binds after k count probes, or stops when
// none of the n searchable slots (max(first_slot,1) up to NUM_SLOTS-1) is free;
// each probe is one count RAM read. o_done is high in the first idle cycle.
// Synchronous reset; valid bits clear all tables at once, slot 0 count reads 1.
// The receiver cannot stall: each result is shown for one cycle only.
module palette_slot_refcount_cache_top #(
    parameter int NUM_PALETTES = pscrc_pkg::NUM_PALETTES_DEF,
    parameter int NUM_SLOTS    = pscrc_pkg::NUM_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [pscrc_pkg::OP_W-1:0]        i_operation,
    input  logic [pscrc_pkg::ID_IN_W-1:0]     i_palette_id,
    output logic                              o_done,
    output logic [pscrc_pkg::SLOT_OUT_W-1:0]  o_slot,
    output logic                              o_load_request,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pscrc_pkg::CFG_W-1:0]       i_cfg_data
);

    pscrc_pkg::t_cmd  w_cmd;
    pscrc_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    pscrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    pscrc_dp #(
        .NUM_PALETTES (NUM_PALETTES),
        .NUM_SLOTS    (NUM_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_operation    (i_operation),
        .i_palette_id   (i_palette_id),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_done         (o_done),
        .o_slot         (o_slot),
        .o_load_request (o_load_request)
    );

    // Result only after the item has finished
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // An accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // Load request only with a result
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load_request |-> o_done)
        else $error("load request without result");

    // Every result closes a busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without preceding work");

endmodule
